>>> rtl/prefix_compressed_block_builder_top_defines.svh
// ----------------------------------------------------------------------------
// Prefix-compressed block builder: assertion macros
// Shared property wrappers for the checker; clock clk, reset rst.
// ----------------------------------------------------------------------------
`ifndef PREFIX_COMPRESSED_BLOCK_BUILDER_TOP_DEFINES_SVH
`define PREFIX_COMPRESSED_BLOCK_BUILDER_TOP_DEFINES_SVH

// checked outside reset only
`define PCBB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define PCBB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/pcbb_pkg.sv
// ----------------------------------------------------------------------------
// Prefix-compressed block builder: package
// Sizes, codes and the types shared by the sequencer and its units.
// ----------------------------------------------------------------------------
package pcbb_pkg;

  localparam int MAX_KEY_BYTES = 32;
  localparam int MAX_RESTARTS  = 15;
  localparam int OFFSET_BITS   = 16;

  localparam int KEY_W     = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int LEN_W     = $clog2(MAX_KEY_BYTES + 1);
  localparam int NB_W      = LEN_W + 1;
  localparam int RC_W      = $clog2(MAX_RESTARTS + 1);
  localparam int VLEN_W    = 14;
  localparam int INTV_W    = 11;
  localparam int ALU_W     = ((OFFSET_BITS > VLEN_W) ? OFFSET_BITS : VLEN_W) + 2;
  localparam int RAM_AW    = KEY_W + 1;
  localparam int RAM_DEPTH = 2 ** RAM_AW;
  localparam int IN_W      = 24;

  localparam logic [INTV_W-1:0] INTERVAL_RST = INTV_W'(16);

  // command codes
  localparam logic [1:0] CMD_KEY    = 2'd0;
  localparam logic [1:0] CMD_VALUE  = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // status codes
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_KEY_LONG = 2'd1;
  localparam logic [1:0] STS_RESTARTS = 2'd2;
  localparam logic [1:0] STS_OFFSET   = 2'd3;

  typedef struct packed {
    logic [1:0] status;
    logic       last;
    logic [7:0] data;
  } beat_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             eq;
  } alu_res_t;

endpackage

>>> rtl/pcbb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pcbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/pcbb_alu.sv
// ----------------------------------------------------------------------------
// Prefix-compressed block builder: shared arithmetic unit
// One adder and one equality compare, time-shared by the sequencer.
// ----------------------------------------------------------------------------
module pcbb_alu (
  input  logic [pcbb_pkg::ALU_W-1:0] a,
  input  logic [pcbb_pkg::ALU_W-1:0] b,
  output pcbb_pkg::alu_res_t         res
);

  always_comb begin
    res.sum = a + b;
    res.eq  = (a == b);
  end

endmodule

>>> rtl/pcbb_obuf.sv
// ----------------------------------------------------------------------------
// Prefix-compressed block builder: output register
// Holds one beat for the master side; takes a new one as the old one leaves.
// ----------------------------------------------------------------------------
module pcbb_obuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  input  pcbb_pkg::beat_t     push_beat,
  output logic                push_ready,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,
  output logic                m_tlast,
  output logic [1:0]          m_tuser
);

  pcbb_pkg::beat_t beat;
  logic            valid;

  assign push_ready = !valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push_valid && push_ready) begin
      valid <= 1'b1;
    end else if (m_tready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid && push_ready) begin
      beat <= push_beat;
    end
  end

  assign m_tvalid = valid;
  assign m_tdata  = beat.data;
  assign m_tlast  = beat.last;
  assign m_tuser  = beat.status;

endmodule

>>> rtl/prefix_compressed_block_builder_top.sv
// ----------------------------------------------------------------------------
// Prefix-compressed block builder: top level
// Sequencer around one shared adder/compare unit, a two-bank key RAM and an
// output register.
//
//   channel  dir  tdata                                tuser     tlast
//   s_*      in   [7:0] data_byte, [21:8] value_length [1:0] cmd end_of_key
//   m_*      out  [7:0] out_byte                       [1:0] sts run_last
//   cfg_*    in   restart_interval, write only         -         -
//
// Key byte without end: compare; value byte: one beat; key past the limit: error.
// Key end: compare, header checks, header beats, a RAM read and a beat per suffix
// byte (adder shared by the checks), offset update; dropped at the end: error
// beat. Finish: one beat per trailer byte, 4 * (restart count + 1) bytes.
// Sync reset; no clearing pass. m_tready low stalls the sequencer at the
// next beat; s_tready is high only while the sequencer is idle.
// ----------------------------------------------------------------------------
module prefix_compressed_block_builder_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [pcbb_pkg::INTV_W-1:0]  cfg_wr_data,  // restart_interval
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [pcbb_pkg::IN_W-1:0]    s_tdata,      // data_byte, value_length
  input  logic [1:0]                   s_tuser,      // command
  input  logic                         s_tlast,      // end_of_key
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [7:0]                   m_tdata,      // out_byte
  output logic [1:0]                   m_tuser,      // status
  output logic                         m_tlast       // run_last
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_KCMP = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_OVF  = 4'd3;
  localparam logic [3:0] S_HDR  = 4'd4;
  localparam logic [3:0] S_SRD  = 4'd5;
  localparam logic [3:0] S_SEM  = 4'd6;
  localparam logic [3:0] S_BWUP = 4'd7;
  localparam logic [3:0] S_VAL  = 4'd8;
  localparam logic [3:0] S_ERR  = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  localparam logic [pcbb_pkg::LEN_W-1:0] KEY_FULL = pcbb_pkg::LEN_W'(pcbb_pkg::MAX_KEY_BYTES);
  localparam logic [pcbb_pkg::RC_W-1:0]  RC_FULL  = pcbb_pkg::RC_W'(pcbb_pkg::MAX_RESTARTS);

  logic [3:0] st;

  // block state
  logic [pcbb_pkg::INTV_W-1:0]      interval;
  logic [pcbb_pkg::LEN_W-1:0]       cur_len;
  logic [pcbb_pkg::LEN_W-1:0]       prev_len;
  logic [pcbb_pkg::LEN_W-1:0]       shared;
  logic                             still;
  logic [pcbb_pkg::INTV_W-1:0]      ksr;
  logic [pcbb_pkg::RC_W-1:0]        rcount;
  logic [pcbb_pkg::OFFSET_BITS-1:0] bw;
  logic                             prev_bank;
  logic [pcbb_pkg::OFFSET_BITS-1:0] offs [pcbb_pkg::MAX_RESTARTS];

  // per-item work registers
  logic [7:0]                       byte_q;
  logic                             eok_q;
  logic [pcbb_pkg::VLEN_W-1:0]      vlen_q;
  logic [1:0]                       err_q;
  logic                             restart_q;
  logic [pcbb_pkg::LEN_W-1:0]       shr_q;
  logic [pcbb_pkg::LEN_W-1:0]       ns_q;
  logic [pcbb_pkg::NB_W-1:0]        nb_q;
  logic [pcbb_pkg::ALU_W-1:0]       acc;
  logic [1:0]                       hstep;
  logic [pcbb_pkg::LEN_W-1:0]       idx;
  logic [pcbb_pkg::RC_W-1:0]        widx;
  logic [1:0]                       bidx;

  // key RAM, bank bit on top
  logic                             ram_we;
  logic [pcbb_pkg::RAM_AW-1:0]      ram_waddr;
  logic [pcbb_pkg::RAM_AW-1:0]      ram_raddr;
  logic [7:0]                       ram_rdata;

  logic [pcbb_pkg::ALU_W-1:0]       alu_a;
  logic [pcbb_pkg::ALU_W-1:0]       alu_b;
  pcbb_pkg::alu_res_t               alu_res;

  logic                             push_valid;
  logic                             push_ready;
  pcbb_pkg::beat_t                  push_beat;
  logic                             fire;

  // end-of-key header figures
  logic                             restart_c;
  logic [pcbb_pkg::LEN_W-1:0]       shr_c;
  logic [pcbb_pkg::LEN_W-1:0]       ns_c;
  logic                             vbig;
  logic [pcbb_pkg::NB_W-1:0]        nb_c;
  logic                             match;
  logic                             sfx_last;
  logic                             hdr_last;
  logic [31:0]                      tword;
  logic [pcbb_pkg::OFFSET_BITS-1:0] off_rd;

  assign s_tready = (st == S_IDLE);
  assign fire     = push_valid && push_ready;

  assign restart_c = (ksr >= interval);
  assign shr_c     = restart_c ? '0 : shared;
  assign ns_c      = cur_len - shr_c;
  assign vbig      = |vlen_q[pcbb_pkg::VLEN_W-1:7];
  assign nb_c      = pcbb_pkg::NB_W'(ns_c) + pcbb_pkg::NB_W'(3) + pcbb_pkg::NB_W'(vbig);
  assign match     = still && (cur_len < prev_len) && alu_res.eq;
  assign sfx_last  = (pcbb_pkg::LEN_W'(idx + 1'b1) == cur_len);
  assign hdr_last  = (ns_q == '0) && (((hstep == 2'd2) && !vbig) || (hstep == 2'd3));

  // entry zero of the restart list is always offset zero
  assign off_rd = (widx == '0 || widx >= RC_FULL) ? '0 : offs[widx];
  assign tword  = (widx == rcount) ? 32'(rcount) : 32'(off_rd);

  // key RAM ports
  always_comb begin
    ram_we    = (st == S_IDLE) && s_tvalid && (s_tuser == pcbb_pkg::CMD_KEY) &&
                (cur_len != KEY_FULL);
    ram_waddr = {~prev_bank, cur_len[pcbb_pkg::KEY_W-1:0]};
    if (st == S_SRD || st == S_SEM) begin
      ram_raddr = {~prev_bank, idx[pcbb_pkg::KEY_W-1:0]};
    end else begin
      ram_raddr = {prev_bank, cur_len[pcbb_pkg::KEY_W-1:0]};
    end
  end

  pcbb_ram #(
    .WIDTH(8),
    .DEPTH(pcbb_pkg::RAM_DEPTH)
  ) u_key_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(s_tdata[7:0]),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // operand select for the shared unit
  always_comb begin
    unique case (st)
      S_KCMP: begin
        alu_a = pcbb_pkg::ALU_W'(ram_rdata);
        alu_b = pcbb_pkg::ALU_W'(byte_q);
      end
      S_CHK: begin
        alu_a = pcbb_pkg::ALU_W'(vlen_q);
        alu_b = pcbb_pkg::ALU_W'(nb_c);
      end
      S_OVF: begin
        alu_a = pcbb_pkg::ALU_W'(bw);
        alu_b = acc;
      end
      S_VAL: begin
        alu_a = pcbb_pkg::ALU_W'(bw);
        alu_b = pcbb_pkg::ALU_W'(1);
      end
      S_BWUP: begin
        alu_a = pcbb_pkg::ALU_W'(bw);
        alu_b = pcbb_pkg::ALU_W'(nb_q);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  pcbb_alu u_alu (
    .a  (alu_a),
    .b  (alu_b),
    .res(alu_res)
  );

  // beat to the output register
  always_comb begin
    push_valid       = 1'b0;
    push_beat.data   = 8'h00;
    push_beat.last   = 1'b0;
    push_beat.status = pcbb_pkg::STS_OK;
    unique case (st)
      S_ERR: begin
        push_valid       = 1'b1;
        push_beat.last   = 1'b1;
        push_beat.status = err_q;
      end
      S_HDR: begin
        push_valid     = 1'b1;
        push_beat.last = hdr_last;
        unique case (hstep)
          2'd0:    push_beat.data = 8'(shr_q);
          2'd1:    push_beat.data = 8'(ns_q);
          2'd2:    push_beat.data = {vbig, vlen_q[6:0]};
          default: push_beat.data = 8'(vlen_q[pcbb_pkg::VLEN_W-1:7]);
        endcase
      end
      S_SEM: begin
        push_valid     = 1'b1;
        push_beat.data = ram_rdata;
        push_beat.last = sfx_last;
      end
      S_VAL: begin
        push_valid     = 1'b1;
        push_beat.data = byte_q;
        push_beat.last = 1'b1;
      end
      S_FIN: begin
        push_valid     = 1'b1;
        push_beat.data = tword[8*bidx +: 8];
        push_beat.last = (widx == rcount) && (bidx == 2'd3);
      end
      default: begin
        push_valid = 1'b0;
      end
    endcase
  end

  pcbb_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_beat (push_beat),
    .push_ready(push_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= pcbb_pkg::INTERVAL_RST;
    end else if (cfg_wr_en) begin
      interval <= cfg_wr_data;
    end
  end

  // item fields and restart offsets
  always_ff @(posedge clk) begin
    if (st == S_IDLE && s_tvalid) begin
      byte_q <= s_tdata[7:0];
      eok_q  <= s_tlast;
      vlen_q <= s_tdata[8 +: pcbb_pkg::VLEN_W];
    end
    if (st == S_BWUP && restart_q) begin
      offs[rcount] <= bw;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      cur_len   <= '0;
      prev_len  <= '0;
      shared    <= '0;
      still     <= 1'b1;
      ksr       <= '0;
      rcount    <= pcbb_pkg::RC_W'(1);
      bw        <= '0;
      prev_bank <= 1'b0;
      err_q     <= pcbb_pkg::STS_OK;
      restart_q <= 1'b0;
      shr_q     <= '0;
      ns_q      <= '0;
      nb_q      <= '0;
      acc       <= '0;
      hstep     <= '0;
      idx       <= '0;
      widx      <= '0;
      bidx      <= '0;
    end else begin
      unique case (st)
        S_IDLE: begin
          if (s_tvalid) begin
            unique case (s_tuser)
              pcbb_pkg::CMD_KEY: begin
                if (cur_len == KEY_FULL) begin
                  err_q   <= pcbb_pkg::STS_KEY_LONG;
                  cur_len <= '0;
                  shared  <= '0;
                  still   <= 1'b1;
                  st      <= S_ERR;
                end else begin
                  st <= S_KCMP;
                end
              end
              pcbb_pkg::CMD_VALUE: begin
                if (&bw) begin
                  err_q <= pcbb_pkg::STS_OFFSET;
                  st    <= S_ERR;
                end else begin
                  st <= S_VAL;
                end
              end
              pcbb_pkg::CMD_FINISH: begin
                widx <= '0;
                bidx <= '0;
                st   <= S_FIN;
              end
              default: begin
                st <= S_IDLE;
              end
            endcase
          end
        end
        S_KCMP: begin
          // RAM now holds the previous key byte at this position
          cur_len <= cur_len + 1'b1;
          shared  <= shared + pcbb_pkg::LEN_W'(match);
          still   <= match;
          st      <= eok_q ? S_CHK : S_IDLE;
        end
        S_CHK: begin
          restart_q <= restart_c;
          shr_q     <= shr_c;
          ns_q      <= ns_c;
          nb_q      <= nb_c;
          acc       <= alu_res.sum;
          if (restart_c && rcount >= RC_FULL) begin
            err_q   <= pcbb_pkg::STS_RESTARTS;
            cur_len <= '0;
            shared  <= '0;
            still   <= 1'b1;
            st      <= S_ERR;
          end else begin
            st <= S_OVF;
          end
        end
        S_OVF: begin
          if (|alu_res.sum[pcbb_pkg::ALU_W-1:pcbb_pkg::OFFSET_BITS]) begin
            err_q   <= pcbb_pkg::STS_OFFSET;
            cur_len <= '0;
            shared  <= '0;
            still   <= 1'b1;
            st      <= S_ERR;
          end else begin
            hstep <= 2'd0;
            st    <= S_HDR;
          end
        end
        S_HDR: begin
          if (fire) begin
            if (hdr_last) begin
              st <= S_BWUP;
            end else if (hstep == 2'd3 || (hstep == 2'd2 && !vbig)) begin
              idx <= shr_q;
              st  <= S_SRD;
            end else begin
              hstep <= hstep + 2'd1;
            end
          end
        end
        S_SRD: begin
          st <= S_SEM;
        end
        S_SEM: begin
          if (fire) begin
            idx <= idx + 1'b1;
            st  <= sfx_last ? S_BWUP : S_SRD;
          end
        end
        S_BWUP: begin
          // header and suffix bytes are added to the block offset here; value bytes in S_VAL
          bw        <= alu_res.sum[pcbb_pkg::OFFSET_BITS-1:0];
          prev_len  <= cur_len;
          prev_bank <= ~prev_bank;
          if (restart_q) begin
            rcount <= rcount + 1'b1;
            ksr    <= pcbb_pkg::INTV_W'(1);
          end else begin
            ksr <= ksr + 1'b1;
          end
          cur_len <= '0;
          shared  <= '0;
          still   <= 1'b1;
          st      <= S_IDLE;
        end
        S_VAL: begin
          if (fire) begin
            bw <= alu_res.sum[pcbb_pkg::OFFSET_BITS-1:0];
            st <= S_IDLE;
          end
        end
        S_ERR: begin
          if (fire) begin
            st <= S_IDLE;
          end
        end
        S_FIN: begin
          if (fire) begin
            if (bidx == 2'd3) begin
              bidx <= 2'd0;
              if (widx == rcount) begin
                prev_len <= '0;
                ksr      <= '0;
                rcount   <= pcbb_pkg::RC_W'(1);
                bw       <= '0;
                cur_len  <= '0;
                shared   <= '0;
                still    <= 1'b1;
                st       <= S_IDLE;
              end else begin
                widx <= widx + 1'b1;
              end
            end else begin
              bidx <= bidx + 2'd1;
            end
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/pcbb_checker.sv
// ----------------------------------------------------------------------------
// Prefix-compressed block builder: port checker
// Watches the top-level ports; attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "prefix_compressed_block_builder_top_defines.svh"

module pcbb_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic [1:0]                  s_tuser,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [7:0]                  m_tdata,
  input logic [1:0]                  m_tuser,
  input logic                        m_tlast
);

  // nothing left in the output register after reset
  `PCBB_ASSERT_ALWAYS(a_out_clear_after_rst, rst |=> !m_tvalid, "beat valid after reset")

  // a stalled beat keeps its payload
  `PCBB_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled beat changed")

  // an error beat is a lone zero byte closing its run
  `PCBB_ASSERT(a_err_beat, m_tvalid && m_tuser != pcbb_pkg::STS_OK |-> m_tlast && m_tdata == 8'h00, "bad error beat")

  // the sequencer is busy in the cycle after every real command is taken
  `PCBB_ASSERT(a_busy_after_cmd, s_tvalid && s_tready && s_tuser != pcbb_pkg::CMD_UNUSED |=> !s_tready, "ready right after a command")

endmodule

bind prefix_compressed_block_builder_top pcbb_checker u_pcbb_checker (.*);

>>> tb/tb_prefix_compressed_block_builder_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench: prefix-compressed block builder
// Streams key, value and finish beats into the block and predicts the encoded
// byte stream (varint headers, key suffixes, passed-through values, restart
// trailer and error beats). Each output beat is checked against the oldest
// prediction. Directed cases first, then random key/value sequences at
// several restart intervals with random stalls.
// ----------------------------------------------------------------------------
module tb_prefix_compressed_block_builder_top;

  localparam int unsigned OFFSET_LIMIT = 32'((longint'(1) << pcbb_pkg::OFFSET_BITS) - 1);
  localparam int          CYCLE_LIMIT  = 2_000_000;
  localparam int          SETTLE       = 80;

  // Predicts the encoded stream; holds its own copy of the block state.
  class block_stream_scoreboard;
    pcbb_pkg::beat_t expected_bytes[$];
    logic [7:0]      prev_key[pcbb_pkg::MAX_KEY_BYTES];
    logic [7:0]      cur_key[pcbb_pkg::MAX_KEY_BYTES];
    int unsigned     prev_len, cur_len, shared_run, since_restart, rcount, written;
    int unsigned     offsets[pcbb_pkg::MAX_RESTARTS];
    int unsigned     interval;
    bit              matching;
    int              fail_count;

    function new();
      interval   = pcbb_pkg::INTERVAL_RST;
      fail_count = 0;
      clear_block();
    endfunction

    function void drop_key();
      cur_len    = 0;
      shared_run = 0;
      matching   = 1'b1;
    endfunction

    function void clear_block();
      foreach (offsets[i]) offsets[i] = 0;
      prev_len      = 0;
      since_restart = 0;
      rcount        = 1;
      written       = 0;
      drop_key();
    endfunction

    function void set_interval(logic [pcbb_pkg::INTV_W-1:0] v);
      interval = v;
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction

    function void push_byte(logic [7:0] b, logic [1:0] st, logic lst);
      pcbb_pkg::beat_t e;
      e.data   = b;
      e.status = st;
      e.last   = lst;
      expected_bytes.insert(expected_bytes.size(), e);
    endfunction

    function void push_varint(int unsigned v);
      while (v >= 128) begin
        push_byte(8'((v & 'h7F) | 'h80), pcbb_pkg::STS_OK, 1'b0);
        v = v >> 7;
      end
      push_byte(8'(v), pcbb_pkg::STS_OK, 1'b0);
    endfunction

    function void push_word(int unsigned v);
      for (int i = 0; i < 4; i++) push_byte(8'(v >> (8 * i)), pcbb_pkg::STS_OK, 1'b0);
    endfunction

    function int unsigned varint_len(int unsigned v);
      return (v < 128) ? 1 : (v < 16384) ? 2 : 3;
    endfunction

    function void note_item(logic [1:0] cmd, logic [7:0] b, logic eok, logic [13:0] vlen);
      int unsigned     pos, shared_len, nonshared, total, start;
      bit              restart;
      pcbb_pkg::beat_t e;
      start = expected_bytes.size();
      case (cmd)
        pcbb_pkg::CMD_KEY: begin
          pos = cur_len;
          if (pos >= pcbb_pkg::MAX_KEY_BYTES) begin
            drop_key();
            push_byte(8'h00, pcbb_pkg::STS_KEY_LONG, 1'b1);
            return;
          end
          cur_key[pos] = b;
          if (matching && pos < prev_len && prev_key[pos] == b) shared_run++;
          else matching = 1'b0;
          cur_len = pos + 1;
          if (!eok) return;
          restart    = since_restart >= interval;
          shared_len = restart ? 0 : shared_run;
          nonshared  = cur_len - shared_len;
          if (restart && rcount >= pcbb_pkg::MAX_RESTARTS) begin
            drop_key();
            push_byte(8'h00, pcbb_pkg::STS_RESTARTS, 1'b1);
            return;
          end
          total = varint_len(shared_len) + varint_len(nonshared) + varint_len(vlen) +
                  nonshared + vlen;
          if (longint'(written) + total > OFFSET_LIMIT) begin
            drop_key();
            push_byte(8'h00, pcbb_pkg::STS_OFFSET, 1'b1);
            return;
          end
          if (restart) begin
            offsets[rcount] = written;
            rcount++;
            since_restart = 0;
          end
          push_varint(shared_len);
          push_varint(nonshared);
          push_varint(vlen);
          for (int i = shared_len; i < cur_len; i++)
            push_byte(cur_key[i], pcbb_pkg::STS_OK, 1'b0);
          written += expected_bytes.size() - start;
          for (int i = 0; i < cur_len; i++) prev_key[i] = cur_key[i];
          prev_len = cur_len;
          since_restart++;
          drop_key();
        end
        pcbb_pkg::CMD_VALUE: begin
          if (written >= OFFSET_LIMIT) begin
            push_byte(8'h00, pcbb_pkg::STS_OFFSET, 1'b1);
            return;
          end
          push_byte(b, pcbb_pkg::STS_OK, 1'b0);
          written++;
        end
        pcbb_pkg::CMD_FINISH: begin
          for (int i = 0; i < rcount && i < pcbb_pkg::MAX_RESTARTS; i++)
            push_word(offsets[i]);
          push_word(rcount);
          clear_block();
        end
        default: ;  // unused code: no effect
      endcase
      if (expected_bytes.size() > start) begin
        e = expected_bytes[expected_bytes.size() - 1];
        e.last = 1'b1;
        expected_bytes[expected_bytes.size() - 1] = e;
      end
    endfunction

    function void flag(string field, int unsigned exp_v, int unsigned act_v);
      fail_count++;
      if (fail_count <= 100) $error("%s: expected %0h, got %0h", field, exp_v, act_v);
    endfunction

    function void check_byte(logic [7:0] data, logic [1:0] status, logic lst);
      pcbb_pkg::beat_t e;
      if (expected_bytes.size() == 0) begin
        fail_count++;
        if (fail_count <= 100)
          $error("unexpected beat: out_byte %0h status %0d run_last %0b", data, status, lst);
        return;
      end
      e = expected_bytes.pop_front();
      if (data !== e.data)     flag("out_byte", e.data, data);
      if (status !== e.status) flag("status", e.status, status);
      if (lst !== e.last)      flag("run_last", e.last, lst);
    endfunction
  endclass

  logic                        clk         = 1'b0;
  logic                        rst         = 1'b1;
  logic                        cfg_wr_en   = 1'b0;
  logic [pcbb_pkg::INTV_W-1:0] cfg_wr_data = '0;
  logic                        s_tvalid    = 1'b0;
  logic                        s_tready;
  logic [pcbb_pkg::IN_W-1:0]   s_tdata     = '0;
  logic [1:0]                  s_tuser     = pcbb_pkg::CMD_KEY;
  logic                        s_tlast     = 1'b0;
  logic                        m_tvalid;
  logic                        m_tready    = 1'b0;
  logic [7:0]                  m_tdata;
  logic [1:0]                  m_tuser;
  logic                        m_tlast;

  block_stream_scoreboard sb = new();

  int         s_max_gap = 9;
  int         m_max_gap = 9;
  int         items_sent = 0;
  int         cycles = 0;
  logic [7:0] last_key[40];
  int         last_len = 0;

  prefix_compressed_block_builder_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // output side: random stall per beat, check on every accepted beat
  initial begin
    int gap;
    wait (!rst);
    @(posedge clk);
    forever begin
      gap = $urandom_range(0, m_max_gap);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_byte(m_tdata, m_tuser, m_tlast);
    end
  end

  // valid stays high across back-to-back beats; only lowered ahead of a gap
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] b, input logic eok,
                           input logic [13:0] vlen);
    int gap;
    gap = $urandom_range(0, s_max_gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tlast  <= eok;
    s_tdata  <= {2'b00, vlen, b};
    do @(posedge clk); while (!s_tready);
    sb.note_item(cmd, b, eok, vlen);
    if (cmd != pcbb_pkg::CMD_UNUSED) items_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_interval(input logic [pcbb_pkg::INTV_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_interval(v);
  endtask

  task automatic send_key(input int len, input logic [13:0] vlen);
    for (int i = 0; i < len; i++)
      send_item(pcbb_pkg::CMD_KEY, 8'($urandom), logic'(i == len - 1),
                (i == len - 1) ? vlen : 14'($urandom));
  endtask

  // mostly well-formed keys sharing a prefix with the previous one, plus noise
  task automatic random_phase(input int n);
    int          start, len, keep, nval, r;
    logic [13:0] vlen;
    logic [7:0]  key_bytes[40];
    start = items_sent;
    while (items_sent - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        r   = $urandom_range(0, 19);
        len = (r == 0) ? $urandom_range(33, 36) :
              (r < 3)  ? $urandom_range(9, 32) : $urandom_range(1, 8);
        keep = $urandom_range(0, (last_len < len) ? last_len : len);
        for (int i = 0; i < len; i++)
          key_bytes[i] = (i < keep) ? last_key[i] : 8'($urandom);
        r    = $urandom_range(0, 9);
        vlen = (r < 6) ? 14'($urandom_range(0, 8)) :
               (r < 8) ? 14'($urandom_range(100, 200)) : 14'($urandom);
        for (int i = 0; i < len; i++)
          send_item(pcbb_pkg::CMD_KEY, key_bytes[i], logic'(i == len - 1),
                    (i == len - 1) ? vlen : 14'($urandom));
        for (int i = 0; i < len; i++) last_key[i] = key_bytes[i];
        last_len = len;
        nval = (vlen < 14'd6) ? int'(vlen) : 6;
        for (int i = 0; i < nval; i++)
          send_item(pcbb_pkg::CMD_VALUE, 8'($urandom), 1'($urandom), 14'($urandom));
      end else if (r < 80) begin
        send_item(pcbb_pkg::CMD_VALUE, 8'($urandom), 1'($urandom), 14'($urandom));
      end else if (r < 88) begin
        send_item(pcbb_pkg::CMD_FINISH, 8'($urandom), 1'($urandom), 14'($urandom));
      end else if (r < 95) begin
        send_item(pcbb_pkg::CMD_UNUSED, 8'($urandom), 1'($urandom), 14'($urandom));
      end else begin
        // key left open; the next key bytes extend it
        r = $urandom_range(1, 3);
        for (int i = 0; i < r; i++)
          send_item(pcbb_pkg::CMD_KEY, 8'($urandom), 1'b0, 14'($urandom));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: reset interval, varint widths, repeated key, ignored code
    send_item(pcbb_pkg::CMD_VALUE, 8'h00, 1'b1, 14'h3FFF);
    send_item(pcbb_pkg::CMD_VALUE, 8'hFF, 1'b0, 14'h0000);
    send_item(pcbb_pkg::CMD_KEY, 8'h00, 1'b1, 14'd0);
    send_item(pcbb_pkg::CMD_KEY, 8'h00, 1'b0, 14'h2AAA);
    send_item(pcbb_pkg::CMD_KEY, 8'hFF, 1'b1, 14'h3FFF);
    send_item(pcbb_pkg::CMD_KEY, 8'h00, 1'b0, 14'h1555);
    send_item(pcbb_pkg::CMD_KEY, 8'hFF, 1'b0, 14'h0000);
    send_item(pcbb_pkg::CMD_KEY, 8'h10, 1'b1, 14'd127);
    send_item(pcbb_pkg::CMD_KEY, 8'h00, 1'b0, 14'd0);
    send_item(pcbb_pkg::CMD_KEY, 8'hFF, 1'b0, 14'd0);
    send_item(pcbb_pkg::CMD_KEY, 8'h10, 1'b1, 14'd128);
    send_item(pcbb_pkg::CMD_UNUSED, 8'hA5, 1'b1, 14'h1555);
    send_item(pcbb_pkg::CMD_KEY, 8'h01, 1'b1, 14'd16383);
    send_item(pcbb_pkg::CMD_KEY, 8'h7E, 1'b0, 14'd0);
    send_item(pcbb_pkg::CMD_FINISH, 8'h5A, 1'b1, 14'h3FFF);
    drain();

    // zero interval: over-long key, then restart on every key past the table
    write_interval(11'd0);
    send_key(pcbb_pkg::MAX_KEY_BYTES + 1, 14'd0);
    send_key(2, 14'd1);
    for (int i = 0; i < 14; i++) send_key(1, 14'($urandom_range(0, 3)));
    send_item(pcbb_pkg::CMD_FINISH, 8'h00, 1'b0, 14'd0);
    drain();

    write_interval(11'd1);
    random_phase(12);
    drain();
    write_interval(11'($urandom_range(2, 6)));
    random_phase(12);
    drain();
    write_interval(11'd1024);
    random_phase(12);
    drain();

    if (sb.fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/pcbb_pkg.sv
rtl/pcbb_ram.sv
rtl/pcbb_alu.sv
rtl/pcbb_obuf.sv
rtl/prefix_compressed_block_builder_top.sv
rtl/pcbb_checker.sv
tb/tb_prefix_compressed_block_builder_top.sv
